// ===== rtl/line_scanner_pcf_sequencer_core_assert.svh =====
// Assertion macros for the line scanner sequencer checker.
`ifndef LINE_SCANNER_PCF_SEQUENCER_CORE_ASSERT_SVH
`define LINE_SCANNER_PCF_SEQUENCER_CORE_ASSERT_SVH

// Clocked assertion that is ignored while reset is held.
`define LSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LSPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lsps_pkg.sv =====
// Package with types and constants of the line scanner sequencer.
`timescale 1ns / 1ps

package lsps_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [3:0] pcf_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] mode_t;

  // Input item kinds.
  localparam kind_t KIND_TICK = 2'd0;
  localparam kind_t KIND_PCF  = 2'd1;
  localparam kind_t KIND_DATA = 2'd2;
  localparam kind_t KIND_ACK  = 2'd3;

  // Line modes.
  localparam mode_t MODE_RESET = 2'd0;
  localparam mode_t MODE_TX    = 2'd1;
  localparam mode_t MODE_RX    = 2'd2;

  // Primary control field states.
  localparam pcf_t PCF_0 = 4'h0;
  localparam pcf_t PCF_1 = 4'h1;
  localparam pcf_t PCF_2 = 4'h2;
  localparam pcf_t PCF_3 = 4'h3;
  localparam pcf_t PCF_4 = 4'h4;
  localparam pcf_t PCF_5 = 4'h5;
  localparam pcf_t PCF_7 = 4'h7;
  localparam pcf_t PCF_8 = 4'h8;
  localparam pcf_t PCF_9 = 4'h9;
  localparam pcf_t PCF_A = 4'hA;
  localparam pcf_t PCF_C = 4'hC;
  localparam pcf_t PCF_D = 4'hD;
  localparam pcf_t PCF_F = 4'hF;

  // Control field bits and line bytes.
  localparam byte_t SVC_FLAG  = 8'h40;
  localparam byte_t DCD_BIT   = 8'h08;
  localparam byte_t PCF0_MASK = 8'h4A;
  localparam byte_t SYN_BYTE  = 8'h32;
  localparam byte_t NO_BYTE   = 8'hFF;

endpackage

// ===== rtl/lsps_if.sv =====
// Channel interfaces for the input items and result items of the sequencer.
`timescale 1ns / 1ps

interface lsps_in_if;
  logic                 valid;
  logic                 ready;
  lsps_pkg::kind_t      kind;
  lsps_pkg::pcf_t       pcf_value;
  lsps_pkg::byte_t      data_byte;
  logic                 rx_valid;
  lsps_pkg::byte_t      rx_byte;
  logic                 l2_busy;

  modport source (output valid, kind, pcf_value, data_byte, rx_valid, rx_byte, l2_busy,
                  input ready);
  modport sink   (input valid, kind, pcf_value, data_byte, rx_valid, rx_byte, l2_busy,
                  output ready);
endinterface

interface lsps_out_if;
  logic                 valid;
  logic                 ready;
  logic                 tx_valid;
  lsps_pkg::byte_t      tx_byte;
  logic                 irq_request;
  lsps_pkg::pcf_t       pcf_state;
  lsps_pkg::byte_t      control_bits;
  lsps_pkg::byte_t      data_out;

  modport source (output valid, tx_valid, tx_byte, irq_request, pcf_state, control_bits,
                  data_out, input ready);
  modport sink   (input valid, tx_valid, tx_byte, irq_request, pcf_state, control_bits,
                  data_out, output ready);
endinterface

// ===== rtl/line_scanner_pcf_sequencer_core.sv =====
// Top level of the single-line scanner PCF control sequencer.
`timescale 1ns / 1ps

// The result of an accepted item is registered in the output register, or in the skid entry.
// Throughput: one item per cycle while the skid entry is empty; the state update is
// a single pass of logic between the sequencer state registers and the result register.
// A two-entry result buffer (output register plus skid) keeps input open while a result waits.
// Reset (rst_n low, synchronous) clears all sequencer state and empties the result buffer.
module line_scanner_pcf_sequencer_core (
  input  logic         clk,
  input  logic         rst_n,
  lsps_in_if.sink      in_ch,
  lsps_out_if.source   out_ch
);

  typedef struct packed {
    logic            tx_valid;
    lsps_pkg::byte_t tx_byte;
    logic            irq_request;
    lsps_pkg::pcf_t  pcf_state;
    lsps_pkg::byte_t control_bits;
    lsps_pkg::byte_t data_out;
  } result_t;

  // Sequencer state.
  lsps_pkg::pcf_t  cur_pcf_r, cur_pcf_nxt;
  lsps_pkg::pcf_t  prev_pcf_r, prev_pcf_nxt;
  lsps_pkg::pcf_t  req_pcf_r, req_pcf_nxt;
  lsps_pkg::byte_t sec_ctl_r, sec_ctl_nxt;
  lsps_pkg::byte_t par_data_r, par_data_nxt;
  lsps_pkg::mode_t line_mode_r, line_mode_nxt;

  // Result buffer.
  result_t res_nxt;
  result_t out_r;
  result_t skid_r;
  logic    out_v_r;
  logic    skid_v_r;

  logic in_fire;
  logic out_fire;

  assign in_ch.ready = !skid_v_r;
  assign in_fire     = in_ch.valid && !skid_v_r;
  assign out_fire    = out_v_r && out_ch.ready;

  // Next state and result of the item on the input channel.
  always_comb begin
    lsps_pkg::pcf_t mid_pcf;
    lsps_pkg::pcf_t mid_prev;
    logic           first;

    cur_pcf_nxt   = cur_pcf_r;
    prev_pcf_nxt  = prev_pcf_r;
    req_pcf_nxt   = req_pcf_r;
    sec_ctl_nxt   = sec_ctl_r;
    par_data_nxt  = par_data_r;
    line_mode_nxt = line_mode_r;
    mid_pcf       = cur_pcf_r;
    mid_prev      = prev_pcf_r;
    first         = 1'b0;
    res_nxt       = '0;

    unique case (in_ch.kind)
      lsps_pkg::KIND_PCF: begin
        req_pcf_nxt = in_ch.pcf_value;
      end
      lsps_pkg::KIND_DATA: begin
        par_data_nxt = in_ch.data_byte;
        sec_ctl_nxt  = sec_ctl_r & ~lsps_pkg::SVC_FLAG;
      end
      lsps_pkg::KIND_ACK: begin
        sec_ctl_nxt = sec_ctl_r & ~lsps_pkg::SVC_FLAG;
      end
      lsps_pkg::KIND_TICK: begin
        sec_ctl_nxt = sec_ctl_r | lsps_pkg::DCD_BIT;
        // Take up a PCF change requested by the host.
        if (cur_pcf_r != req_pcf_r) begin
          if (req_pcf_r == lsps_pkg::PCF_0) begin
            line_mode_nxt = lsps_pkg::MODE_RESET;
          end
          mid_prev = cur_pcf_r;
          mid_pcf  = req_pcf_r;
        end
        first = (mid_prev != mid_pcf);

        // State rule of the current PCF.
        case (mid_pcf) inside
          lsps_pkg::PCF_0: begin
            sec_ctl_nxt = sec_ctl_nxt & lsps_pkg::PCF0_MASK;
          end
          lsps_pkg::PCF_1, lsps_pkg::PCF_2, lsps_pkg::PCF_3, lsps_pkg::PCF_F: begin
            if (first) begin
              sec_ctl_nxt         = sec_ctl_nxt | lsps_pkg::SVC_FLAG;
              req_pcf_nxt         = lsps_pkg::PCF_0;
              res_nxt.irq_request = 1'b1;
            end
          end
          lsps_pkg::PCF_4, lsps_pkg::PCF_5: begin
            if (line_mode_nxt != lsps_pkg::MODE_RESET && line_mode_nxt != lsps_pkg::MODE_TX &&
                in_ch.rx_valid && in_ch.rx_byte == lsps_pkg::SYN_BYTE) begin
              par_data_nxt = in_ch.rx_byte;
              req_pcf_nxt  = lsps_pkg::PCF_7;
            end
          end
          lsps_pkg::PCF_7: begin
            if (!in_ch.l2_busy && (sec_ctl_nxt & lsps_pkg::SVC_FLAG) == '0) begin
              par_data_nxt        = in_ch.rx_valid ? in_ch.rx_byte : lsps_pkg::NO_BYTE;
              sec_ctl_nxt         = sec_ctl_nxt | lsps_pkg::SVC_FLAG;
              req_pcf_nxt         = lsps_pkg::PCF_7;
              res_nxt.irq_request = 1'b1;
            end
          end
          lsps_pkg::PCF_8, lsps_pkg::PCF_9, lsps_pkg::PCF_A: begin
            if (!in_ch.l2_busy && (sec_ctl_nxt & lsps_pkg::SVC_FLAG) == '0) begin
              res_nxt.tx_valid    = 1'b1;
              res_nxt.tx_byte     = par_data_r;
              sec_ctl_nxt         = sec_ctl_nxt | lsps_pkg::SVC_FLAG;
              req_pcf_nxt         = lsps_pkg::PCF_9;
              res_nxt.irq_request = 1'b1;
            end
          end
          lsps_pkg::PCF_C, lsps_pkg::PCF_D: begin
            if (first) begin
              if (mid_pcf == lsps_pkg::PCF_C) begin
                line_mode_nxt = lsps_pkg::MODE_RX;
              end
              sec_ctl_nxt         = sec_ctl_nxt | lsps_pkg::SVC_FLAG;
              req_pcf_nxt         = lsps_pkg::PCF_5;
              res_nxt.irq_request = 1'b1;
            end
          end
          default: begin
          end
        endcase

        prev_pcf_nxt = mid_pcf;
        cur_pcf_nxt  = req_pcf_nxt;
      end
      default: begin
      end
    endcase

    res_nxt.pcf_state    = cur_pcf_nxt;
    res_nxt.control_bits = sec_ctl_nxt;
    res_nxt.data_out     = par_data_nxt;
  end

  // Sequencer state registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pcf_r   <= lsps_pkg::PCF_0;
      prev_pcf_r  <= lsps_pkg::PCF_0;
      req_pcf_r   <= lsps_pkg::PCF_0;
      sec_ctl_r   <= '0;
      par_data_r  <= '0;
      line_mode_r <= lsps_pkg::MODE_RESET;
    end else if (in_fire) begin
      cur_pcf_r   <= cur_pcf_nxt;
      prev_pcf_r  <= prev_pcf_nxt;
      req_pcf_r   <= req_pcf_nxt;
      sec_ctl_r   <= sec_ctl_nxt;
      par_data_r  <= par_data_nxt;
      line_mode_r <= line_mode_nxt;
    end
  end

  // Result buffer control: output register in front, skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_fire) begin
          skid_v_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_v_r && !out_fire) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_fire) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.tx_valid     = out_r.tx_valid;
  assign out_ch.tx_byte      = out_r.tx_byte;
  assign out_ch.irq_request  = out_r.irq_request;
  assign out_ch.pcf_state    = out_r.pcf_state;
  assign out_ch.control_bits = out_r.control_bits;
  assign out_ch.data_out     = out_r.data_out;

endmodule

// ===== rtl/lsps_checker.sv =====
// Port-level checker for the line scanner sequencer and its bind statement.
`timescale 1ns / 1ps
`include "line_scanner_pcf_sequencer_core_assert.svh"

module lsps_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_tx_valid,
  input logic            out_irq_request,
  input lsps_pkg::pcf_t  out_pcf_state,
  input lsps_pkg::byte_t out_control_bits
);

  // The result buffer is empty right after reset.
  `LSPS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // Input is only held off when a result is waiting at the output.
  `LSPS_ASSERT(a_ready_backpressure, !in_ready |-> out_valid, "input stalled with no result")

  // A stalled result keeps its state fields.
  `LSPS_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_pcf_state) && $stable(out_control_bits),
    "stalled result changed")

  // A transmitted byte always comes with an interrupt, the service flag and PCF 9.
  `LSPS_ASSERT(a_tx_irq,
    out_valid && out_tx_valid |-> out_irq_request && out_control_bits[6] &&
      out_pcf_state == lsps_pkg::PCF_9,
    "transmit without service request")

  // An item accepted into an empty buffer shows its result in the next cycle.
  `LSPS_ASSERT(a_accept_result,
    in_valid && in_ready && !out_valid |=> out_valid,
    "accepted item gave no result")

endmodule

bind line_scanner_pcf_sequencer_core lsps_checker u_lsps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_tx_valid     (out_ch.tx_valid),
  .out_irq_request  (out_ch.irq_request),
  .out_pcf_state    (out_ch.pcf_state),
  .out_control_bits (out_ch.control_bits)
);

// ===== tb/sv/lsps_tb_pkg.sv =====
// Item types and the result scoreboard for the line scanner sequencer testbench.
`timescale 1ns / 1ps

package lsps_tb_pkg;
  import lsps_pkg::*;

  // One input item as it crosses the input channel.
  typedef struct packed {
    kind_t kind;
    pcf_t  pcf_value;
    byte_t data_byte;
    logic  rx_valid;
    byte_t rx_byte;
    logic  l2_busy;
  } scan_event_t;

  // One result item as it crosses the result channel.
  typedef struct packed {
    logic  tx_valid;
    byte_t tx_byte;
    logic  irq_request;
    pcf_t  pcf_state;
    byte_t control_bits;
    byte_t data_out;
  } line_result_t;

  // Tracks the sequencer state, predicts each result and checks what the block returns.
  class pcf_result_checker;
    pcf_t         cur_pcf;
    pcf_t         prev_pcf;
    pcf_t         req_pcf;
    byte_t        ctrl_field;
    byte_t        par_data;
    mode_t        line_mode;
    line_result_t expected_q[$];
    int           mismatches;
    int           results_seen;
    int           tx_count;
    int           irq_count;
    int           kind_count[4];

    function new();
      cur_pcf    = PCF_0;
      prev_pcf   = PCF_0;
      req_pcf    = PCF_0;
      ctrl_field = '0;
      par_data   = '0;
      line_mode  = MODE_RESET;
      mismatches = 0;
      results_seen = 0;
      tx_count   = 0;
      irq_count  = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    // Applies one item to the sequencer state and returns the result it causes.
    function line_result_t step_sequencer(scan_event_t ev);
      line_result_t r;
      logic         first_entry;
      r = '0;
      case (ev.kind)
        KIND_PCF: begin
          req_pcf = ev.pcf_value;
        end
        KIND_DATA: begin
          par_data   = ev.data_byte;
          ctrl_field = ctrl_field & ~SVC_FLAG;
        end
        KIND_ACK: begin
          ctrl_field = ctrl_field & ~SVC_FLAG;
        end
        default: begin
          ctrl_field = ctrl_field | DCD_BIT;
          // A host request is taken up at the start of the tick.
          if (cur_pcf != req_pcf) begin
            if (req_pcf == PCF_0) line_mode = MODE_RESET;
            prev_pcf = cur_pcf;
            cur_pcf  = req_pcf;
          end
          first_entry = (prev_pcf != cur_pcf);
          case (cur_pcf)
            PCF_0: begin
              ctrl_field = ctrl_field & PCF0_MASK;
            end
            PCF_1, PCF_2, PCF_3, PCF_F: begin
              if (first_entry) begin
                ctrl_field    = ctrl_field | SVC_FLAG;
                req_pcf       = PCF_0;
                r.irq_request = 1'b1;
              end
            end
            PCF_4, PCF_5: begin
              // Sync hunt only listens while the line is in receive mode.
              if (line_mode != MODE_RESET && line_mode != MODE_TX && ev.rx_valid &&
                  ev.rx_byte == SYN_BYTE) begin
                par_data = ev.rx_byte;
                req_pcf  = PCF_7;
              end
            end
            PCF_7: begin
              if (!ev.l2_busy && (ctrl_field & SVC_FLAG) == '0) begin
                par_data      = ev.rx_valid ? ev.rx_byte : NO_BYTE;
                ctrl_field    = ctrl_field | SVC_FLAG;
                req_pcf       = PCF_7;
                r.irq_request = 1'b1;
              end
            end
            PCF_8, PCF_9, PCF_A: begin
              if (!ev.l2_busy && (ctrl_field & SVC_FLAG) == '0) begin
                r.tx_valid    = 1'b1;
                r.tx_byte     = par_data;
                ctrl_field    = ctrl_field | SVC_FLAG;
                req_pcf       = PCF_9;
                r.irq_request = 1'b1;
              end
            end
            PCF_C, PCF_D: begin
              if (first_entry) begin
                if (cur_pcf == PCF_C) line_mode = MODE_RX;
                ctrl_field    = ctrl_field | SVC_FLAG;
                req_pcf       = PCF_5;
                r.irq_request = 1'b1;
              end
            end
            default: begin
            end
          endcase
          prev_pcf = cur_pcf;
          cur_pcf  = req_pcf;
        end
      endcase
      r.pcf_state    = cur_pcf;
      r.control_bits = ctrl_field;
      r.data_out     = par_data;
      return r;
    endfunction

    // Records an accepted input item and queues its expected result.
    function void note_item(scan_event_t ev);
      kind_count[ev.kind]++;
      expected_q.push_back(step_sequencer(ev));
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    // Compares an accepted result with the oldest expectation, field by field.
    task check_result(line_result_t got);
      line_result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
      end else begin
        exp = expected_q.pop_front();
        if (got.tx_valid !== exp.tx_valid)
          report_mismatch($sformatf("result %0d tx_valid %b, expected %b",
                                    results_seen, got.tx_valid, exp.tx_valid));
        if (got.tx_byte !== exp.tx_byte)
          report_mismatch($sformatf("result %0d tx_byte %h, expected %h",
                                    results_seen, got.tx_byte, exp.tx_byte));
        if (got.irq_request !== exp.irq_request)
          report_mismatch($sformatf("result %0d irq_request %b, expected %b",
                                    results_seen, got.irq_request, exp.irq_request));
        if (got.pcf_state !== exp.pcf_state)
          report_mismatch($sformatf("result %0d pcf_state %h, expected %h",
                                    results_seen, got.pcf_state, exp.pcf_state));
        if (got.control_bits !== exp.control_bits)
          report_mismatch($sformatf("result %0d control_bits %h, expected %h",
                                    results_seen, got.control_bits, exp.control_bits));
        if (got.data_out !== exp.data_out)
          report_mismatch($sformatf("result %0d data_out %h, expected %h",
                                    results_seen, got.data_out, exp.data_out));
        if (exp.tx_valid) tx_count++;
        if (exp.irq_request) irq_count++;
      end
      results_seen++;
    endtask
  endclass

endpackage

// ===== tb/sv/line_scanner_pcf_sequencer_core_tb.sv =====
// Top testbench of the line scanner sequencer: directed and random items with checked results.
`timescale 1ns / 1ps

module line_scanner_pcf_sequencer_core_tb;
  import lsps_pkg::*;
  import lsps_tb_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 175;
  localparam int TAIL_CYCLES  = 10;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  int   items_driven;

  pcf_t rx_entry[2]  = '{PCF_C, PCF_D};
  pcf_t tx_entry[3]  = '{PCF_8, PCF_9, PCF_A};
  pcf_t irq_entry[6] = '{PCF_1, PCF_2, PCF_3, PCF_F, PCF_0, PCF_4};

  pcf_result_checker sb;

  lsps_in_if  in_ch ();
  lsps_out_if out_ch ();

  line_scanner_pcf_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready changes at the falling edge, stalling at the current rate.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitors: results are checked and accepted items noted at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_result('{out_ch.tx_valid, out_ch.tx_byte, out_ch.irq_request,
                          out_ch.pcf_state, out_ch.control_bits, out_ch.data_out});
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        sb.note_item('{in_ch.kind, in_ch.pcf_value, in_ch.data_byte, in_ch.rx_valid,
                       in_ch.rx_byte, in_ch.l2_busy});
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", sb.expected_q.size());
      $display("line_scanner_pcf_sequencer_core_tb NOT OK");
      $finish;
    end
  end

  // Fully random item; the ignored fields of every kind stay random.
  function automatic scan_event_t rand_item();
    scan_event_t ev;
    ev.kind      = kind_t'($urandom_range(3));
    ev.pcf_value = pcf_t'($urandom_range(15));
    ev.data_byte = byte_t'($urandom_range(255));
    ev.rx_valid  = 1'($urandom_range(1));
    ev.rx_byte   = byte_t'($urandom_range(255));
    ev.l2_busy   = 1'($urandom_range(1));
    return ev;
  endfunction

  // Drives one item from a falling edge and returns at the falling edge after acceptance.
  task automatic send_item(input scan_event_t ev);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= ev.kind;
    in_ch.pcf_value <= ev.pcf_value;
    in_ch.data_byte <= ev.data_byte;
    in_ch.rx_valid  <= ev.rx_valid;
    in_ch.rx_byte   <= ev.rx_byte;
    in_ch.l2_busy   <= ev.l2_busy;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_driven++;
    @(negedge clk);
  endtask

  task automatic send_tick(input logic rxv, input byte_t rxb, input logic busy);
    scan_event_t ev;
    ev          = rand_item();
    ev.kind     = KIND_TICK;
    ev.rx_valid = rxv;
    ev.rx_byte  = rxb;
    ev.l2_busy  = busy;
    send_item(ev);
  endtask

  task automatic send_host(input kind_t k, input pcf_t p, input byte_t d);
    scan_event_t ev;
    ev           = rand_item();
    ev.kind      = k;
    ev.pcf_value = p;
    ev.data_byte = d;
    send_item(ev);
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // Directed walk through every state group and the host events.
  task automatic run_directed();
    send_tick(1'b0, 8'h00, 1'b0);
    // Interrupt state entered once, then back to zero with the mask applied.
    send_host(KIND_PCF, PCF_1, 8'h00);
    send_tick(1'b1, 8'hFF, 1'b0);
    send_tick(1'b0, 8'h00, 1'b0);
    send_host(KIND_ACK, PCF_F, 8'hFF);
    // A sync byte while the line is still in reset mode is ignored.
    send_host(KIND_PCF, PCF_4, 8'hFF);
    send_tick(1'b1, SYN_BYTE, 1'b1);
    // Turnaround into receive, sync hunt, then receive with and without a byte.
    send_host(KIND_PCF, PCF_C, 8'h00);
    send_tick(1'b0, 8'h00, 1'b0);
    send_tick(1'b1, 8'hFF, 1'b0);
    send_tick(1'b1, SYN_BYTE, 1'b0);
    send_tick(1'b1, 8'hFF, 1'b0);
    send_host(KIND_ACK, PCF_0, 8'h00);
    send_tick(1'b1, 8'hA5, 1'b1);
    send_tick(1'b0, 8'h5A, 1'b0);
    send_host(KIND_ACK, PCF_0, 8'h00);
    send_tick(1'b1, 8'h00, 1'b0);
    // Transmit with the extreme bytes, held once by the level 2 interrupt.
    send_host(KIND_DATA, PCF_0, 8'hFF);
    send_host(KIND_PCF, PCF_8, 8'h00);
    send_tick(1'b0, 8'h00, 1'b0);
    send_host(KIND_DATA, PCF_F, 8'h00);
    send_tick(1'b1, 8'hFF, 1'b1);
    send_tick(1'b1, 8'hFF, 1'b0);
    // Turnaround that keeps the line mode, then the last interrupt state.
    send_host(KIND_PCF, PCF_D, 8'hFF);
    send_tick(1'b0, 8'h00, 1'b0);
    send_host(KIND_PCF, PCF_F, 8'h00);
    send_tick(1'b1, SYN_BYTE, 1'b0);
  endtask

  // Receive session: turnaround, sync hunt and a run of received bytes.
  task automatic rx_session();
    int n;
    send_host(KIND_PCF, ($urandom_range(99) < 80) ? rx_entry[0] : rx_entry[1],
              byte_t'($urandom_range(255)));
    send_tick(1'($urandom_range(1)), byte_t'($urandom_range(255)), 1'($urandom_range(1)));
    n = $urandom_range(3);
    repeat (n)
      send_tick(1'($urandom_range(1)), byte_t'($urandom_range(255)), 1'($urandom_range(1)));
    if ($urandom_range(99) < 90) send_tick(1'b1, SYN_BYTE, 1'($urandom_range(1)));
    n = $urandom_range(8, 2);
    repeat (n) begin
      if ($urandom_range(1)) send_host(KIND_ACK, pcf_t'($urandom_range(15)), 8'h00);
      send_tick(1'($urandom_range(1)), byte_t'($urandom_range(255)),
                ($urandom_range(3) == 0));
    end
  endtask

  // Transmit session: host data writes or acknowledges, each followed by ticks.
  task automatic tx_session();
    int n;
    send_host(KIND_PCF, tx_entry[$urandom_range(2)], byte_t'($urandom_range(255)));
    n = $urandom_range(8, 2);
    repeat (n) begin
      if ($urandom_range(4) == 0)
        send_host(KIND_ACK, pcf_t'($urandom_range(15)), byte_t'($urandom_range(255)));
      else
        send_host(KIND_DATA, pcf_t'($urandom_range(15)), byte_t'($urandom_range(255)));
      repeat ($urandom_range(2, 1))
        send_tick(1'($urandom_range(1)), byte_t'($urandom_range(255)),
                  ($urandom_range(3) == 0));
    end
  endtask

  // Interrupt or idle states, followed by ticks and an acknowledge.
  task automatic irq_session();
    send_host(KIND_PCF, irq_entry[$urandom_range(5)], byte_t'($urandom_range(255)));
    repeat ($urandom_range(3, 1))
      send_tick(1'($urandom_range(1)), byte_t'($urandom_range(255)), 1'($urandom_range(1)));
    send_host(KIND_ACK, pcf_t'($urandom_range(15)), byte_t'($urandom_range(255)));
  endtask

  // Random part of one idling phase.
  task automatic run_random(input int count);
    int start;
    int pick;
    start = items_driven;
    while (items_driven - start < count) begin
      pick = $urandom_range(99);
      if (pick < 35)
        rx_session();
      else if (pick < 65)
        tx_session();
      else if (pick < 80)
        irq_session();
      else
        repeat ($urandom_range(3, 1)) send_item(rand_item());
    end
  endtask

  // Main sequence: reset, directed items, then four idling phases.
  initial begin
    sb              = new();
    idle_pct        = 0;
    stall_pct       = 0;
    quiet_cycles    = 0;
    items_driven    = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TICK;
    in_ch.pcf_value = PCF_0;
    in_ch.data_byte = '0;
    in_ch.rx_valid  = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.l2_busy   = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    wait_drained();

    idle_pct = 0;  stall_pct = 0;  run_random(PHASE_ITEMS); wait_drained();
    idle_pct = 77; stall_pct = 0;  run_random(PHASE_ITEMS); wait_drained();
    idle_pct = 0;  stall_pct = 77; run_random(PHASE_ITEMS); wait_drained();
    idle_pct = 30; stall_pct = 30; run_random(PHASE_ITEMS); wait_drained();

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d items: %0d ticks, %0d PCF writes, %0d data writes, %0d acks.",
             items_driven, sb.kind_count[KIND_TICK], sb.kind_count[KIND_PCF],
             sb.kind_count[KIND_DATA], sb.kind_count[KIND_ACK]);
    $display("Checked %0d results with %0d line bytes sent and %0d interrupt pulses.",
             sb.results_seen, sb.tx_count, sb.irq_count);
    if (sb.mismatches == 0) begin
      $display("line_scanner_pcf_sequencer_core_tb OK");
    end else begin
      $display("line_scanner_pcf_sequencer_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lsps_pkg.sv
rtl/lsps_if.sv
rtl/line_scanner_pcf_sequencer_core.sv
rtl/lsps_checker.sv
tb/sv/lsps_tb_pkg.sv
tb/sv/line_scanner_pcf_sequencer_core_tb.sv
